[hw/rtl/slr_pkg.sv]
// Package for the spot light radiance block: item types, stage records, register indexes.
// Also holds the elaboration-time square root used to build the exp2 constant table.
// No dependencies; every other file uses it by scoped names.
package slr_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_POSITION   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPOT_AXIS        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTENSITY        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_INNER        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_OUTER        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FALLOFF_EXPONENT = 3'd5;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        radiance_red;
    logic [15:0]        radiance_green;
    logic [15:0]        radiance_blue;
    logic               at_light;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             at_light;
    logic [33:0]      len2;
    logic [2:0][15:0] dir;
  } vec_t;

  typedef struct packed {
    logic             valid;
    logic             at_light;
    logic [33:0]      len2;
    logic [2:0][15:0] dir;
    logic [16:0]      falloff;
  } fall_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_w;
    rem   = val;
    root  = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bit_w) begin
        rem  = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Q0.30 value of 2^(-2^-idx) for idx from 1 to 16.
  function automatic logic [29:0] exp_root(input int unsigned idx);
    logic [63:0] k;
    k = isqrt64(64'd1 << 59);
    for (int unsigned i = 1; i < idx; i++) begin
      k = isqrt64(k << 30);
    end
    return k[29:0];
  endfunction

endpackage

[hw/rtl/slr_vec.sv]
// Vector stage: offset to the light, squared length, square root and unit direction.
// Square root and the three divisions run one result bit per pipeline stage.
// Depends on slr_pkg.
module slr_vec (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  slr_pkg::point_t       in_point,
  input  logic [47:0]           light_position,
  output slr_pkg::vec_t         out
);

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIR_BITS   = 16;
  localparam logic [15:0] Q14_ONE    = 16'd16384;

  typedef struct packed {
    logic             valid;
    logic [2:0]       neg;
    logic [2:0][15:0] ad;
    logic [33:0]      len2;
    logic [63:0]      rem;
    logic [63:0]      root;
  } sqrt_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       neg;
    logic [33:0]      len2;
    logic [31:0]      ls;
    logic [2:0][47:0] rem;
    logic [2:0][15:0] quo;
  } div_t;

  logic               d_valid;
  logic signed [16:0] diff [3];
  logic [15:0]        ad_c [3];
  logic               s_valid;
  logic [2:0]         s_neg;
  logic [15:0]        s_ad [3];
  logic [31:0]        s_sq [3];
  sqrt_t              sq_pipe [SQRT_STEPS+1];
  div_t               dv [DIR_BITS+1];
  slr_pkg::vec_t      out_next;
  logic [15:0]        mag [3];

  always_ff @(posedge clk) begin
    if (en) begin
      d_valid <= in_valid;
      diff[0] <= {light_position[15], light_position[15:0]}
               - {in_point.point_x[15], in_point.point_x};
      diff[1] <= {light_position[31], light_position[31:16]}
               - {in_point.point_y[15], in_point.point_y};
      diff[2] <= {light_position[47], light_position[47:32]}
               - {in_point.point_z[15], in_point.point_z};
    end
    if (rst) d_valid <= 1'b0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad_c[i] = diff[i][16] ? 16'(-diff[i]) : diff[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_valid <= d_valid;
      for (int i = 0; i < 3; i++) begin
        s_neg[i] <= diff[i][16];
        s_ad[i]  <= ad_c[i];
        s_sq[i]  <= ad_c[i] * ad_c[i];
      end
    end
    if (rst) s_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pipe[0].valid <= s_valid;
      sq_pipe[0].neg   <= s_neg;
      sq_pipe[0].ad    <= {s_ad[2], s_ad[1], s_ad[0]};
      sq_pipe[0].len2  <= 34'(s_sq[0]) + 34'(s_sq[1]) + 34'(s_sq[2]);
      sq_pipe[0].rem   <= 64'({34'(s_sq[0]) + 34'(s_sq[1]) + 34'(s_sq[2]), 28'd0});
      sq_pipe[0].root  <= '0;
    end
    if (rst) sq_pipe[0].valid <= 1'b0;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT_W = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sq_pipe[j].root + BIT_W;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_pipe[j+1] <= sq_pipe[j];
        if (sq_pipe[j].rem >= trial) begin
          sq_pipe[j+1].rem  <= sq_pipe[j].rem - trial;
          sq_pipe[j+1].root <= (sq_pipe[j].root >> 1) + BIT_W;
        end else begin
          sq_pipe[j+1].root <= sq_pipe[j].root >> 1;
        end
      end
      if (rst) sq_pipe[j+1].valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].valid <= sq_pipe[SQRT_STEPS].valid;
      dv[0].neg   <= sq_pipe[SQRT_STEPS].neg;
      dv[0].len2  <= sq_pipe[SQRT_STEPS].len2;
      dv[0].ls    <= sq_pipe[SQRT_STEPS].root[31:0];
      dv[0].quo   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv[0].rem[i] <= 48'({sq_pipe[SQRT_STEPS].ad[i], 28'd0})
                      + 48'(sq_pipe[SQRT_STEPS].root[31:1]);
      end
    end
    if (rst) dv[0].valid <= 1'b0;
  end

  for (genvar b = 0; b < DIR_BITS; b++) begin : g_div
    localparam int unsigned SH = DIR_BITS - 1 - b;
    logic [47:0] dsub;
    assign dsub = 48'(dv[b].ls) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        dv[b+1] <= dv[b];
        for (int i = 0; i < 3; i++) begin
          if (dv[b].rem[i] >= dsub) begin
            dv[b+1].rem[i]     <= dv[b].rem[i] - dsub;
            dv[b+1].quo[i][SH] <= 1'b1;
          end
        end
      end
      if (rst) dv[b+1].valid <= 1'b0;
    end
  end

  always_comb begin
    out_next.valid    = dv[DIR_BITS].valid;
    out_next.at_light = dv[DIR_BITS].len2 == '0;
    out_next.len2     = dv[DIR_BITS].len2;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (dv[DIR_BITS].quo[i] > Q14_ONE) ? Q14_ONE : dv[DIR_BITS].quo[i];
      if (out_next.at_light) begin
        out_next.dir[i] = '0;
      end else if (dv[DIR_BITS].neg[i]) begin
        out_next.dir[i] = 16'(-mag[i]);
      end else begin
        out_next.dir[i] = mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) out <= out_next;
    if (rst) out.valid <= 1'b0;
  end

endmodule

[hw/rtl/slr_fall.sv]
// Cone falloff: cosine to the spot axis, cone ratio division, log2 by squaring, exp2 by table.
// Each division bit, squaring and table multiply has its own pipeline stage.
// Depends on slr_pkg.
module slr_fall (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  slr_pkg::vec_t in_vec,
  input  logic [47:0]   spot_axis,
  input  logic [15:0]   cos_inner,
  input  logic [15:0]   cos_outer,
  input  logic [15:0]   falloff_exponent,
  output slr_pkg::fall_t out
);

  localparam int unsigned RATIO_BITS = 17;
  localparam int unsigned LOG_STEPS  = 16;
  localparam int unsigned EXP_STEPS  = 16;
  localparam logic [16:0] F_ONE      = 17'd65536;

  typedef enum logic [1:0] {MODE_ZERO, MODE_ONE, MODE_CALC} mode_t;

  typedef struct packed {
    slr_pkg::vec_t side;
    mode_t         mode;
    logic [33:0]   rem;
    logic [15:0]   den;
    logic [16:0]   quo;
  } rdiv_t;

  typedef struct packed {
    slr_pkg::vec_t side;
    mode_t         mode;
    logic [3:0]    k;
    logic [31:0]   x;
    logic [15:0]   frac;
  } lg_t;

  typedef struct packed {
    slr_pkg::vec_t side;
    mode_t         mode;
    logic [4:0]    n;
    logic [15:0]   fr;
    logic [30:0]   v;
  } ex_t;

  slr_pkg::vec_t      p_side;
  logic signed [31:0] p_prod [3];
  slr_pkg::vec_t      c_side;
  logic signed [19:0] c_val;
  logic signed [33:0] dot_sum;
  logic signed [19:0] ci_ext;
  logic signed [19:0] co_ext;
  logic signed [19:0] c_diff;
  logic signed [19:0] c_span;
  mode_t              q_mode;
  rdiv_t              rd [RATIO_BITS+1];
  lg_t                lg [LOG_STEPS+1];
  logic [16:0]        ratio;
  mode_t              l_mode;
  logic [3:0]         l_k;
  slr_pkg::vec_t      m_side;
  mode_t              m_mode;
  logic [36:0]        m_val;
  logic [20:0]        m_wd;
  logic [36:0]        t_sum;
  ex_t                ex [EXP_STEPS+1];
  logic [31:0]        f_sum;
  slr_pkg::fall_t     out_next;

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= in_vec;
      for (int i = 0; i < 3; i++) begin
        p_prod[i] <= $signed(in_vec.dir[i]) * $signed(spot_axis[16*i +: 16]);
      end
    end
    if (rst) p_side.valid <= 1'b0;
  end

  assign dot_sum = p_prod[0] + p_prod[1] + p_prod[2];

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= p_side;
      c_val  <= 20'((dot_sum + 34'sd8192) >>> 14);
    end
    if (rst) c_side.valid <= 1'b0;
  end

  assign ci_ext = {{4{cos_inner[15]}}, cos_inner};
  assign co_ext = {{4{cos_outer[15]}}, cos_outer};
  assign c_diff = c_val - co_ext;
  assign c_span = ci_ext - co_ext;

  always_comb begin
    if (c_val < co_ext) begin
      q_mode = MODE_ZERO;
    end else if (c_val > ci_ext || ci_ext <= co_ext) begin
      q_mode = MODE_ONE;
    end else begin
      q_mode = MODE_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd[0].side <= c_side;
      rd[0].mode <= q_mode;
      rd[0].rem  <= 34'({c_diff[15:0], 16'd0});
      rd[0].den  <= c_span[15:0];
      rd[0].quo  <= '0;
    end
    if (rst) rd[0].side.valid <= 1'b0;
  end

  for (genvar b = 0; b < RATIO_BITS; b++) begin : g_ratio
    localparam int unsigned SH = RATIO_BITS - 1 - b;
    logic [33:0] dsub;
    assign dsub = 34'(rd[b].den) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        rd[b+1] <= rd[b];
        if (rd[b].rem >= dsub) begin
          rd[b+1].rem     <= rd[b].rem - dsub;
          rd[b+1].quo[SH] <= 1'b1;
        end
      end
      if (rst) rd[b+1].side.valid <= 1'b0;
    end
  end

  assign ratio = rd[RATIO_BITS].quo;

  always_comb begin
    l_mode = rd[RATIO_BITS].mode;
    if (rd[RATIO_BITS].mode == MODE_CALC) begin
      if (ratio[16]) begin
        l_mode = MODE_ONE;
      end else if (ratio == '0) begin
        l_mode = (falloff_exponent == '0) ? MODE_ONE : MODE_ZERO;
      end
    end
    l_k = '0;
    for (int i = 0; i < 16; i++) begin
      if (ratio[i]) l_k = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg[0].side <= rd[RATIO_BITS].side;
      lg[0].mode <= l_mode;
      lg[0].k    <= l_k;
      lg[0].x    <= 32'(ratio[15:0]) << (5'd30 - {1'b0, l_k});
      lg[0].frac <= '0;
    end
    if (rst) lg[0].side.valid <= 1'b0;
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    logic [61:0] sqr;
    logic [31:0] xs;
    assign sqr = lg[j].x[30:0] * lg[j].x[30:0];
    assign xs  = sqr[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        lg[j+1] <= lg[j];
        if (xs[31]) begin
          lg[j+1].x    <= xs >> 1;
          lg[j+1].frac <= {lg[j].frac[14:0], 1'b1};
        end else begin
          lg[j+1].x    <= xs;
          lg[j+1].frac <= {lg[j].frac[14:0], 1'b0};
        end
      end
      if (rst) lg[j+1].side.valid <= 1'b0;
    end
  end

  assign m_wd = 21'h100000 - {1'b0, lg[LOG_STEPS].k, lg[LOG_STEPS].frac};

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= lg[LOG_STEPS].side;
      m_mode <= lg[LOG_STEPS].mode;
      m_val  <= 37'(m_wd) * 37'(falloff_exponent);
    end
    if (rst) m_side.valid <= 1'b0;
  end

  assign t_sum = m_val + 37'd2048;

  always_ff @(posedge clk) begin
    if (en) begin
      ex[0].side <= m_side;
      ex[0].mode <= (m_mode == MODE_CALC && t_sum[36:28] > 9'd16) ? MODE_ZERO : m_mode;
      ex[0].n    <= t_sum[32:28];
      ex[0].fr   <= t_sum[27:12];
      ex[0].v    <= 31'h40000000;
    end
    if (rst) ex[0].side.valid <= 1'b0;
  end

  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
    localparam logic [29:0] EXP_K = slr_pkg::exp_root(i + 1);
    logic [61:0] prod;
    assign prod = 62'(ex[i].v) * 62'(EXP_K) + 62'h20000000;
    always_ff @(posedge clk) begin
      if (en) begin
        ex[i+1] <= ex[i];
        if (ex[i].fr[EXP_STEPS-1-i]) ex[i+1].v <= prod[60:30];
      end
      if (rst) ex[i+1].side.valid <= 1'b0;
    end
  end

  assign f_sum = 32'(ex[EXP_STEPS].v) + (32'd1 << (6'd13 + {1'b0, ex[EXP_STEPS].n}));

  always_comb begin
    out_next.valid    = ex[EXP_STEPS].side.valid;
    out_next.at_light = ex[EXP_STEPS].side.at_light;
    out_next.len2     = ex[EXP_STEPS].side.len2;
    out_next.dir      = ex[EXP_STEPS].side.dir;
    case (ex[EXP_STEPS].mode)
      MODE_ZERO: out_next.falloff = '0;
      MODE_ONE:  out_next.falloff = F_ONE;
      default:   out_next.falloff = 17'(f_sum >> (6'd14 + {1'b0, ex[EXP_STEPS].n}));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) out <= out_next;
    if (rst) out.valid <= 1'b0;
  end

endmodule

[hw/rtl/slr_rad.sv]
// Radiance stage: intensity times falloff, divided by squared distance with saturation.
// The division runs one quotient bit per pipeline stage; the last stage is the output register.
// Depends on slr_pkg.
module slr_rad (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  slr_pkg::fall_t   in_fall,
  input  logic [47:0]      intensity,
  output logic             result_valid,
  output slr_pkg::result_t result
);

  localparam int unsigned RAD_BITS = 16;

  typedef struct packed {
    slr_pkg::fall_t   side;
    logic [2:0]       sat;
    logic [2:0][49:0] rem;
    logic [2:0][15:0] quo;
  } rdv_t;

  slr_pkg::fall_t   m_side;
  logic [32:0]      m_prod [3];
  logic [33:0]      num [3];
  logic [49:0]      lim;
  rdv_t             dv [RAD_BITS+1];
  slr_pkg::result_t res_next;
  logic [15:0]      rad [3];

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= in_fall;
      for (int i = 0; i < 3; i++) begin
        m_prod[i] <= 33'(intensity[16*i +: 16]) * 33'(in_fall.falloff);
      end
    end
    if (rst) m_side.valid <= 1'b0;
  end

  assign lim = {m_side.len2, 16'd0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = 34'(m_prod[i]) + (m_side.len2 >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].side <= m_side;
      dv[0].quo  <= '0;
      for (int i = 0; i < 3; i++) begin
        dv[0].sat[i] <= 50'(num[i]) >= lim;
        dv[0].rem[i] <= 50'(num[i]);
      end
    end
    if (rst) dv[0].side.valid <= 1'b0;
  end

  for (genvar b = 0; b < RAD_BITS; b++) begin : g_div
    localparam int unsigned SH = RAD_BITS - 1 - b;
    logic [49:0] dsub;
    assign dsub = 50'(dv[b].side.len2) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        dv[b+1] <= dv[b];
        for (int i = 0; i < 3; i++) begin
          if (dv[b].rem[i] >= dsub) begin
            dv[b+1].rem[i]     <= dv[b].rem[i] - dsub;
            dv[b+1].quo[i][SH] <= 1'b1;
          end
        end
      end
      if (rst) dv[b+1].side.valid <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv[RAD_BITS].side.at_light) begin
        rad[i] = '0;
      end else if (dv[RAD_BITS].sat[i]) begin
        rad[i] = 16'hFFFF;
      end else begin
        rad[i] = dv[RAD_BITS].quo[i];
      end
    end
    res_next.dir_x          = dv[RAD_BITS].side.dir[0];
    res_next.dir_y          = dv[RAD_BITS].side.dir[1];
    res_next.dir_z          = dv[RAD_BITS].side.dir[2];
    res_next.radiance_red   = rad[0];
    res_next.radiance_green = rad[1];
    res_next.radiance_blue  = rad[2];
    res_next.at_light       = dv[RAD_BITS].side.at_light;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv[RAD_BITS].side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) result <= res_next;
  end

endmodule

[hw/rtl/spot_light_radiance.sv]
// Spot light radiance with inverse-square attenuation: top level, registers and flow control.
// Instantiates slr_vec, slr_fall and slr_rad; depends on slr_pkg.
//
// One shaded point is accepted per clock cycle while the output is not stalled.
// The depth comes from the bit-per-stage square root, the three divisions and the
// bit-per-stage log2 and exp2 of the cone falloff. A stalled output freezes the whole
// pipeline; a one-item input buffer keeps point_ready a register, so one more point is
// taken while a finished result waits. Register writes are expected only while idle.
module spot_light_radiance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_ready,
  input  slr_pkg::point_t                     point,
  output logic                                result_valid,
  input  logic                                result_ready,
  output slr_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [slr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [slr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [47:0]     light_position;
  logic [47:0]     spot_axis;
  logic [47:0]     intensity;
  logic [15:0]     cos_inner;
  logic [15:0]     cos_outer;
  logic [15:0]     falloff_exponent;
  logic            adv;
  logic            skid_valid;
  slr_pkg::point_t skid_point;
  logic            ent_valid;
  slr_pkg::point_t ent_point;
  slr_pkg::vec_t   vec;
  slr_pkg::fall_t  fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_position   <= '0;
      spot_axis        <= 48'd16384;
      intensity        <= '0;
      cos_inner        <= 16'd16384;
      cos_outer        <= '0;
      falloff_exponent <= 16'd4096;
    end else if (cfg_write) begin
      unique case (cfg_index)
        slr_pkg::CFG_LIGHT_POSITION:   light_position   <= cfg_data;
        slr_pkg::CFG_SPOT_AXIS:        spot_axis        <= cfg_data;
        slr_pkg::CFG_INTENSITY:        intensity        <= cfg_data;
        slr_pkg::CFG_COS_INNER:        cos_inner        <= cfg_data[15:0];
        slr_pkg::CFG_COS_OUTER:        cos_outer        <= cfg_data[15:0];
        slr_pkg::CFG_FALLOFF_EXPONENT: falloff_exponent <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign adv         = !result_valid || result_ready;
  assign point_ready = !skid_valid;
  assign ent_valid   = skid_valid || point_valid;
  assign ent_point   = skid_valid ? skid_point : point;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (point_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && point_valid && !skid_valid) skid_point <= point;
  end

  slr_vec u_vec (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .in_valid       (ent_valid),
    .in_point       (ent_point),
    .light_position (light_position),
    .out            (vec)
  );

  slr_fall u_fall (
    .clk              (clk),
    .rst              (rst),
    .en               (adv),
    .in_vec           (vec),
    .spot_axis        (spot_axis),
    .cos_inner        (cos_inner),
    .cos_outer        (cos_outer),
    .falloff_exponent (falloff_exponent),
    .out              (fall)
  );

  slr_rad u_rad (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_fall      (fall),
    .intensity    (intensity),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
